// ===== rtl/core/mcet_pkg.sv =====
`timescale 1ns / 1ps

package mcet_pkg;

    localparam int NUM_CLIENTS = 8;
    localparam int IDX_W       = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam int CNT_W       = $clog2(NUM_CLIENTS + 1);
    localparam int TIME_W      = 64;
    localparam int SLEEP_W     = 32;
    localparam int MASK_W      = 8;
    localparam int CLIENT_W    = 3;
    localparam int KIND_W      = 3;

    typedef enum logic [KIND_W-1:0] {
        K_ARM     = 3'd0,
        K_DISABLE = 3'd1,
        K_DIS_ALL = 3'd2,
        K_QUERY   = 3'd3,
        K_DISP    = 3'd4,
        K_CHECK   = 3'd5
    } t_kind;

    typedef struct packed {
        logic             start;
        logic             step;
        logic             query;
        logic             disp;
        logic [IDX_W-1:0] idx;
        logic             en;
        logic             hnd;
    } t_scan_ctl;

    typedef struct packed {
        logic                   found;
        logic [IDX_W-1:0]       earliest;
        logic [SLEEP_W-1:0]     sleep;
        logic [NUM_CLIENTS-1:0] expired;
        logic [NUM_CLIENTS-1:0] called;
    } t_scan_res;

    function automatic logic [MASK_W-1:0] fit_mask(input logic [NUM_CLIENTS-1:0] m);
        logic [NUM_CLIENTS+MASK_W-1:0] t;
        t = {{MASK_W{1'b0}}, m};
        return t[MASK_W-1:0];
    endfunction

    function automatic logic [CLIENT_W-1:0] fit_client(input logic [IDX_W-1:0] c);
        logic [IDX_W+CLIENT_W-1:0] t;
        t = {{CLIENT_W{1'b0}}, c};
        return t[CLIENT_W-1:0];
    endfunction

endpackage

// ===== rtl/core/mcet_in_if.sv =====
`timescale 1ns / 1ps

interface mcet_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [2:0]  client;
    logic [63:0] timeout_us;
    logic [63:0] now_us;

    modport source (output valid, kind, client, timeout_us, now_us, input ready);
    modport sink   (input valid, kind, client, timeout_us, now_us, output ready);
endinterface

// ===== rtl/core/mcet_out_if.sv =====
`timescale 1ns / 1ps

interface mcet_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [2:0]  earliest_client;
    logic [31:0] wait_us;
    logic [7:0]  expired_mask;
    logic [7:0]  called_mask;

    modport source (output valid, found, earliest_client, wait_us, expired_mask,
                    called_mask, input ready);
    modport sink   (input valid, found, earliest_client, wait_us, expired_mask,
                    called_mask, output ready);
endinterface

// ===== rtl/core/mcet_cfg_if.sv =====
`timescale 1ns / 1ps

interface mcet_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] handler_present;

    modport source (output valid, handler_present, input ready);
    modport sink   (input valid, handler_present, output ready);
endinterface

// ===== rtl/core/mcet_ram.sv =====
`timescale 1ns / 1ps

module mcet_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/mcet_scan.sv =====
`timescale 1ns / 1ps

module mcet_scan (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mcet_pkg::t_scan_ctl            i_ctl,
    input  logic [mcet_pkg::TIME_W-1:0]    i_rdata,
    input  logic [mcet_pkg::TIME_W-1:0]    i_now,
    output mcet_pkg::t_scan_res            o_res
);
    import mcet_pkg::*;

    logic                   r_found;
    logic [IDX_W-1:0]       r_earliest;
    logic [TIME_W-1:0]      r_best;
    logic [NUM_CLIENTS-1:0] r_expired;
    logic [NUM_CLIENTS-1:0] r_called;
    logic [TIME_W-1:0]      diff;
    logic [SLEEP_W-1:0]     sleep;
    logic [NUM_CLIENTS-1:0] bit_sel;

    assign bit_sel = NUM_CLIENTS'(1) << i_ctl.idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found    <= 1'b0;
            r_expired  <= '0;
            r_called   <= '0;
        end else if (i_ctl.start) begin
            r_found    <= 1'b0;
            r_expired  <= '0;
            r_called   <= '0;
        end else if (i_ctl.step) begin
            if (i_ctl.query && i_ctl.en && (!r_found || i_rdata < r_best)) begin
                r_found <= 1'b1;
            end
            if (i_ctl.disp && i_ctl.en && i_rdata <= i_now) begin
                r_expired <= r_expired | bit_sel;
                if (i_ctl.hnd) begin
                    r_called <= r_called | bit_sel;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_best     <= '0;
            r_earliest <= '0;
        end else if (i_ctl.step && i_ctl.query && i_ctl.en
                     && (!r_found || i_rdata < r_best)) begin
            r_best     <= i_rdata;
            r_earliest <= i_ctl.idx;
        end
    end

    always_comb begin
        diff = r_best - i_now;
        if (!r_found || diff == '0 || diff[TIME_W-1]) begin
            sleep = '0;
        end else if (|diff[TIME_W-1:SLEEP_W]) begin
            sleep = '1;
        end else begin
            sleep = diff[SLEEP_W-1:0];
        end
    end

    assign o_res.found    = r_found;
    assign o_res.earliest = r_found ? r_earliest : '0;
    assign o_res.sleep    = sleep;
    assign o_res.expired  = r_expired;
    assign o_res.called   = r_called;

endmodule

// ===== rtl/core/multi_client_expiry_timer_core.sv =====
`timescale 1ns / 1ps

// Multi-client expiry timer.
// i_cmd carries one command word: kind, client, timeout_us and now_us.
// o_rsp returns exactly one result word for every command, in order.
// i_cfg writes the handler_present mask; write it only while idle.
// Expiry times sit in an 8 x 64 synchronous RAM; enable bits in flops.
// Arm, disable, disable-all and unknown kinds go from S_EXEC to S_FIN;
// check-one reads its single RAM entry in S_SCAN; query and dispatch
// walk the RAM in S_SCAN one entry a cycle, set by the single RAM read
// port.
// One command is in flight at a time; the next is accepted once the
// result is loaded into the output register.
// If the receiver stalls, the result holds in the output register and a
// second finished result waits in the final state until it drains.
// Synchronous reset clears enables, handler mask and the output valid;
// RAM contents are only used for enabled clients, so need no clearing.
module multi_client_expiry_timer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcet_in_if.sink    i_cmd,
    mcet_out_if.source o_rsp,
    mcet_cfg_if.sink   i_cfg
);
    import mcet_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    logic [KIND_W-1:0]      r_kind;
    logic [CLIENT_W-1:0]    r_client;
    logic [TIME_W-1:0]      r_dur;
    logic [TIME_W-1:0]      r_now;
    logic [NUM_CLIENTS-1:0] r_en, n_en;
    logic [MASK_W-1:0]      r_hp;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic                   r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]       r_rd_idx, n_rd_idx;
    logic                   r_out_vld;
    logic                   r_o_found;
    logic [CLIENT_W-1:0]    r_o_client;
    logic [SLEEP_W-1:0]     r_o_sleep;
    logic [MASK_W-1:0]      r_o_exp;
    logic [MASK_W-1:0]      r_o_call;

    logic [IDX_W+CLIENT_W-1:0]     client_ext;
    logic [IDX_W-1:0]              caddr;
    logic                          in_range;
    logic [NUM_CLIENTS+MASK_W-1:0] hp_ext;
    logic                          ram_we;
    logic [IDX_W-1:0]              ram_raddr;
    logic [TIME_W-1:0]             ram_rdata;
    logic                          load_out;
    t_scan_ctl                     scan_ctl;
    t_scan_res                     scan_res;

    assign client_ext = {{IDX_W{1'b0}}, r_client};
    assign caddr      = client_ext[IDX_W-1:0];
    assign in_range   = 32'(r_client) < NUM_CLIENTS;
    assign hp_ext     = {{NUM_CLIENTS{1'b0}}, r_hp};

    assign i_cmd.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign load_out    = (r_state == S_FIN) && (!r_out_vld || o_rsp.ready);
    assign ram_we      = (r_state == S_EXEC) && (r_kind == K_ARM) && in_range;

    always_comb begin
        n_state  = r_state;
        n_en     = r_en;
        n_idx    = r_idx;
        n_rd_vld = 1'b0;
        n_rd_idx = r_rd_idx;
        ram_raddr = r_idx[IDX_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
                case (r_kind)
                    K_ARM: begin
                        if (in_range) begin
                            n_en = r_en | (NUM_CLIENTS'(1) << caddr);
                        end
                    end
                    K_DISABLE: begin
                        if (in_range) begin
                            n_en = r_en & ~(NUM_CLIENTS'(1) << caddr);
                        end
                    end
                    K_DIS_ALL: begin
                        n_en = '0;
                    end
                    K_QUERY, K_DISP: begin
                        ram_raddr = '0;
                        n_rd_vld  = 1'b1;
                        n_rd_idx  = '0;
                        n_idx     = CNT_W'(1);
                        n_state   = S_SCAN;
                    end
                    K_CHECK: begin
                        if (in_range) begin
                            ram_raddr = caddr;
                            n_rd_vld  = 1'b1;
                            n_rd_idx  = caddr;
                            n_idx     = CNT_W'(NUM_CLIENTS);
                            n_state   = S_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                if (32'(r_idx) < NUM_CLIENTS) begin
                    ram_raddr = r_idx[IDX_W-1:0];
                    n_rd_vld  = 1'b1;
                    n_rd_idx  = r_idx[IDX_W-1:0];
                    n_idx     = r_idx + CNT_W'(1);
                end
                if (!r_rd_vld) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_en = r_en & ~scan_res.expired;
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_en      <= '0;
            r_hp      <= '0;
            r_rd_vld  <= 1'b0;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_en     <= n_en;
            r_rd_vld <= n_rd_vld;
            r_idx    <= n_idx;
            if (i_cfg.valid) begin
                r_hp <= i_cfg.handler_present;
            end
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= n_rd_idx;
        if (i_cmd.valid && i_cmd.ready) begin
            r_kind   <= i_cmd.kind;
            r_client <= i_cmd.client;
            r_dur    <= i_cmd.timeout_us;
            r_now    <= i_cmd.now_us;
        end
        if (load_out) begin
            r_o_found  <= scan_res.found;
            r_o_client <= fit_client(scan_res.earliest);
            r_o_sleep  <= scan_res.sleep;
            r_o_exp    <= fit_mask(scan_res.expired);
            r_o_call   <= fit_mask(scan_res.called);
        end
    end

    assign scan_ctl.start = (r_state == S_EXEC);
    assign scan_ctl.step  = (r_state == S_SCAN) && r_rd_vld;
    assign scan_ctl.query = (r_kind == K_QUERY);
    assign scan_ctl.disp  = (r_kind == K_DISP) || (r_kind == K_CHECK);
    assign scan_ctl.idx   = r_rd_idx;
    assign scan_ctl.en    = r_en[r_rd_idx];
    assign scan_ctl.hnd   = hp_ext[r_rd_idx];

    mcet_ram #(
        .WIDTH (TIME_W),
        .DEPTH (NUM_CLIENTS)
    ) u_expiry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (caddr),
        .i_wdata (r_now + r_dur),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mcet_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_rdata (ram_rdata),
        .i_now   (r_now),
        .o_res   (scan_res)
    );

    assign o_rsp.valid           = r_out_vld;
    assign o_rsp.found           = r_o_found;
    assign o_rsp.earliest_client = r_o_client;
    assign o_rsp.wait_us         = r_o_sleep;
    assign o_rsp.expired_mask    = r_o_exp;
    assign o_rsp.called_mask     = r_o_call;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import mcet_pkg::*;

    localparam int          HALF_PERIOD    = 10;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          SEGMENTS       = 9;
    localparam int          SEGMENT_WORDS  = 150;
    localparam logic [2:0]  K_SPARE_LO     = 3'd6;
    localparam logic [2:0]  K_SPARE_HI     = 3'd7;
    localparam logic [63:0] TIME_MAX       = '1;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [CLIENT_W-1:0] client;
        logic [TIME_W-1:0]   timeout_us;
        logic [TIME_W-1:0]   now_us;
    } t_timer_cmd;

    typedef struct packed {
        logic                found;
        logic [CLIENT_W-1:0] earliest_client;
        logic [SLEEP_W-1:0]  wait_us;
        logic [MASK_W-1:0]   expired_mask;
        logic [MASK_W-1:0]   called_mask;
    } t_timer_rsp;

    class t_expiry_scoreboard;
        logic [TIME_W-1:0]      expiry_at [NUM_CLIENTS];
        logic [NUM_CLIENTS-1:0] armed;
        logic [MASK_W-1:0]      handlers;
        t_timer_rsp             owed [$];
        int                     errors;

        function new();
            armed    = '0;
            handlers = '0;
            errors   = 0;
            foreach (expiry_at[i]) expiry_at[i] = '0;
        endfunction

        function void set_handlers(logic [MASK_W-1:0] m);
            handlers = m;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function logic [SLEEP_W-1:0] sleep_until(logic [TIME_W-1:0] due,
                                                 logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] d;
            d = due - now;
            if (d == '0 || d[TIME_W-1])
                return '0;
            if (d > 64'h0000_0000_FFFF_FFFF)
                return '1;
            return d[SLEEP_W-1:0];
        endfunction

        function void note_command(t_timer_cmd c);
            t_timer_rsp             e;
            logic [TIME_W-1:0]      best;
            logic [NUM_CLIENTS-1:0] gone;
            e    = '0;
            best = '0;
            gone = '0;
            case (c.kind)
                K_ARM: begin
                    if (c.client < NUM_CLIENTS) begin
                        expiry_at[c.client] = c.now_us + c.timeout_us;
                        armed[c.client]     = 1'b1;
                    end
                end
                K_DISABLE: begin
                    if (c.client < NUM_CLIENTS)
                        armed[c.client] = 1'b0;
                end
                K_DIS_ALL: armed = '0;
                K_QUERY: begin
                    for (int i = 0; i < NUM_CLIENTS; i++) begin
                        if (armed[i] && (!e.found || expiry_at[i] < best)) begin
                            best              = expiry_at[i];
                            e.earliest_client = 3'(i);
                            e.found           = 1'b1;
                        end
                    end
                    if (e.found)
                        e.wait_us = sleep_until(best, c.now_us);
                end
                K_DISP: begin
                    for (int i = 0; i < NUM_CLIENTS; i++)
                        if (armed[i] && expiry_at[i] <= c.now_us)
                            gone[i] = 1'b1;
                    armed = armed & ~gone;
                end
                K_CHECK: begin
                    if (c.client < NUM_CLIENTS && armed[c.client]
                        && expiry_at[c.client] <= c.now_us) begin
                        gone[c.client]  = 1'b1;
                        armed[c.client] = 1'b0;
                    end
                end
                default: ;
            endcase
            e.expired_mask = gone[MASK_W-1:0];
            e.called_mask  = gone[MASK_W-1:0] & handlers;
            owed.push_back(e);
        endfunction

        task report(string msg);
            $display("mismatch @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        endtask

        task check_result(t_timer_rsp r);
            t_timer_rsp e;
            if (owed.size() == 0) begin
                report("result word with nothing outstanding");
            end else begin
                e = owed.pop_front();
                check_field("found", r.found, e.found);
                check_field("earliest_client", r.earliest_client, e.earliest_client);
                check_field("wait_us", r.wait_us, e.wait_us);
                check_field("expired_mask", r.expired_mask, e.expired_mask);
                check_field("called_mask", r.called_mask, e.called_mask);
            end
        endtask

        task close();
            if (owed.size() != 0)
                report($sformatf("%0d result words never arrived", owed.size()));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    int                 tx_idle_pct;
    int                 rx_idle_pct;
    int                 quiet_cycles;
    logic [TIME_W-1:0]  clock_us;
    t_expiry_scoreboard sb;

    mcet_in_if  cmd_ch ();
    mcet_out_if rsp_ch ();
    mcet_cfg_if cfg_ch ();

    multi_client_expiry_timer_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) < rx_idle_pct) ? 1'b0 : 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready)
            sb.note_command('{cmd_ch.kind, cmd_ch.client, cmd_ch.timeout_us,
                              cmd_ch.now_us});
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready)
            sb.set_handlers(cfg_ch.handler_present);
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result('{rsp_ch.found, rsp_ch.earliest_client, rsp_ch.wait_us,
                              rsp_ch.expired_mask, rsp_ch.called_mask});
    end

    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", quiet_cycles + 1);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task drain();
        cmd_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    task send(t_timer_cmd c);
        while ($urandom_range(99) < tx_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.kind       <= c.kind;
        cmd_ch.client     <= c.client;
        cmd_ch.timeout_us <= c.timeout_us;
        cmd_ch.now_us     <= c.now_us;
        do @(posedge i_clk); while (!cmd_ch.ready);
        @(negedge i_clk);
    endtask

    task issue(logic [2:0] kind, logic [2:0] client, logic [63:0] dur, logic [63:0] now);
        send('{kind, client, dur, now});
    endtask

    task write_handlers(logic [MASK_W-1:0] m);
        drain();
        cfg_ch.valid           <= 1'b1;
        cfg_ch.handler_present <= m;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_timer_cmd random_cmd();
        t_timer_cmd  c;
        int unsigned pick;
        c.client = 3'($urandom_range(7));
        case ($urandom_range(9))
            0:       clock_us = {$urandom, $urandom};
            1:       clock_us = clock_us + $urandom;
            default: clock_us = clock_us + $urandom_range(300);
        endcase
        c.now_us = ($urandom_range(19) == 0) ? {$urandom, $urandom} : clock_us;
        case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: c.timeout_us = 64'($urandom_range(1000));
            10, 11, 12: c.timeout_us = {30'd0, 2'($urandom_range(3)), $urandom};
            13, 14, 15: c.timeout_us = {$urandom, $urandom};
            16, 17:     c.timeout_us = {32'hFFFF_FFFF, $urandom};
            18:         c.timeout_us = '0;
            default:    c.timeout_us = TIME_MAX - $urandom_range(100);
        endcase
        pick = $urandom_range(99);
        if (pick < 34)
            c.kind = K_ARM;
        else if (pick < 42)
            c.kind = K_DISABLE;
        else if (pick < 45)
            c.kind = K_DIS_ALL;
        else if (pick < 67)
            c.kind = K_QUERY;
        else if (pick < 80)
            c.kind = K_DISP;
        else if (pick < 95)
            c.kind = K_CHECK;
        else
            c.kind = $urandom_range(1) ? K_SPARE_HI : K_SPARE_LO;
        return c;
    endfunction

    initial begin
        logic [MASK_W-1:0] m;
        sb                     = new();
        i_clk                  = 1'b0;
        i_rst_n                = 1'b0;
        quiet_cycles           = 0;
        clock_us               = '0;
        tx_idle_pct            = 17;
        rx_idle_pct            = 88;
        cmd_ch.valid           = 1'b0;
        cmd_ch.kind            = '0;
        cmd_ch.client          = '0;
        cmd_ch.timeout_us      = '0;
        cmd_ch.now_us          = '0;
        rsp_ch.ready           = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.handler_present = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_handlers(8'hA5);
        issue(K_QUERY,    3'd0, '0, '0);
        issue(K_ARM,      3'd0, TIME_MAX, '0);
        issue(K_QUERY,    3'd0, '0, '0);
        issue(K_ARM,      3'd7, '0, TIME_MAX);
        issue(K_QUERY,    3'd7, '0, 64'd5);
        issue(K_ARM,      3'd3, 64'd100, 64'd1000);
        issue(K_QUERY,    3'd0, '0, 64'd1000);
        issue(K_QUERY,    3'd0, '0, 64'd1100);
        issue(K_ARM,      3'd5, 64'h0000_0100_0000_0000, '0);
        issue(K_DISABLE,  3'd3, '0, '0);
        issue(K_QUERY,    3'd0, '0, '0);
        issue(K_ARM,      3'd1, 64'd5, 64'd10);
        issue(K_CHECK,    3'd1, '0, 64'd14);
        issue(K_CHECK,    3'd1, '0, 64'd15);
        issue(K_CHECK,    3'd2, '0, TIME_MAX);
        issue(K_ARM,      3'd2, 64'd1, TIME_MAX);
        issue(K_ARM,      3'd4, TIME_MAX, TIME_MAX);
        issue(K_DISP,     3'd0, '0, TIME_MAX);
        issue(K_QUERY,    3'd0, '0, TIME_MAX);
        issue(K_SPARE_LO, 3'd6, TIME_MAX, TIME_MAX);
        issue(K_SPARE_HI, 3'd7, 64'h5555_AAAA_5555_AAAA, 64'hAAAA_5555_AAAA_5555);
        issue(K_ARM,      3'd6, 64'd3, '0);
        issue(K_DIS_ALL,  3'd0, '0, '0);
        issue(K_QUERY,    3'd0, '0, '0);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 3) begin
                tx_idle_pct = 88;
                rx_idle_pct = 17;
            end else if (seg == 6) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (seg)
                0, 8:    m = 8'h00;
                1, 7:    m = 8'hFF;
                3:       m = 8'h01;
                4:       m = 8'h80;
                default: m = 8'($urandom);
            endcase
            write_handlers(m);
            repeat (SEGMENT_WORDS) begin
                if ($urandom_range(199) == 0)
                    drain();
                send(random_cmd());
            end
        end

        drain();
        repeat (30) @(posedge i_clk);
        sb.close();
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
